// File: rtl/core/pcli_pkg.sv
// Shared types and constants for the piecewise cubic Lagrange interpolator.
package pcli_pkg;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  localparam int ONE_Q16 = 65536;

  typedef struct packed {
    logic               kind;
    logic [7:0]         node_index;
    logic signed [31:0] node_position;
    logic signed [31:0] node_value;
    logic signed [31:0] query_x;
  } item_t;

  typedef struct packed {
    logic signed [31:0] spline_value;
    logic               in_range;
  } result_t;

endpackage

// File: rtl/core/pcli_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pcli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 193
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/piecewise_cubic_lagrange_interp.sv
// Piecewise cubic Lagrange interpolator: grid memories, scan and weight sequencer.
//
//   channel   signals                          dir  accepted when
//   --------  -------------------------------  ---  ----------------------------
//   command   start, busy, item                in   start && !busy
//   result    done, result                     out  every cycle done is high
//   config    cfg_valid, cfg_ready, cfg_data   in   cfg_valid && cfg_ready
//
// A load word leaves busy low. An evaluate word holds busy while it scans the
// elements and, once an element is found, while the bit-serial divider (one
// quotient bit per cycle over a 50-bit dividend) and the multiplier form the
// weights. The node memories have no reset and need no clearing pass. The
// result is shown for one cycle with done.
module piecewise_cubic_lagrange_interp #(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  pcli_pkg::item_t   item,
  output logic              done,
  output pcli_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [6:0]        cfg_data
);
  import pcli_pkg::*;

  localparam int DEPTH = 3 * MAX_ELEMENTS + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int EW    = $clog2(MAX_ELEMENTS + 1);

  localparam logic [3:0] OP_GA  = 4'd2;
  localparam logic [3:0] OP_W0B = 4'd4;
  localparam logic [3:0] OP_W0C = 4'd5;
  localparam logic [3:0] OP_W1C = 4'd8;
  localparam logic [3:0] OP_W2C = 4'd11;
  localparam logic [3:0] OP_W3C = 4'd13;

  localparam logic [5:0] DIV_LAST = 6'd49;

  typedef enum logic [16:0] {
    ST_IDLE  = 17'd1,
    ST_RD0   = 17'd2,
    ST_RD3   = 17'd4,
    ST_CHK   = 17'd8,
    ST_RD1   = 17'd16,
    ST_RD2   = 17'd32,
    ST_DIVST = 17'd64,
    ST_DIV   = 17'd128,
    ST_DIVEND= 17'd256,
    ST_MAB   = 17'd512,
    ST_MSAT1 = 17'd1024,
    ST_MC    = 17'd2048,
    ST_MSAT2 = 17'd4096,
    ST_MF    = 17'd8192,
    ST_MACC  = 17'd16384,
    ST_FIN   = 17'd32768,
    ST_SPARE = 17'd65536
  } state_t;

  function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
    logic ok;
    ok = (v[47:31] == {17{1'b0}}) || (v[47:31] == {17{1'b1}});
    if (ok) begin
      return v[31:0];
    end
    return v[47] ? 32'sh80000000 : 32'sh7fffffff;
  endfunction

  function automatic logic signed [31:0] sat50(input logic signed [49:0] v);
    logic ok;
    ok = (v[49:31] == {19{1'b0}}) || (v[49:31] == {19{1'b1}});
    if (ok) begin
      return v[31:0];
    end
    return v[49] ? 32'sh80000000 : 32'sh7fffffff;
  endfunction

  function automatic logic signed [33:0] ext34(input logic signed [31:0] v);
    return {{2{v[31]}}, v};
  endfunction

  state_t state;
  logic [6:0]         element_count;
  logic [EW-1:0]      count_eff;
  logic [EW-1:0]      ecnt;
  logic [AW-1:0]      b0;
  logic signed [31:0] qx, p0, p1, p2, p3;
  logic signed [31:0] k, be, ga;
  logic signed [31:0] fac0, fac1, fac2;
  logic [1:0]         wj;
  logic [3:0]         op;
  logic [5:0]         dcnt;
  logic [34:0]        rem;
  logic [49:0]        qr;
  logic [33:0]        dmag;
  logic               dneg;
  logic signed [63:0] prod;
  logic signed [31:0] wt;
  logic signed [49:0] acc;
  logic signed [31:0] rval;
  logic               found;

  logic               load_we;
  logic [AW-1:0]      waddr;
  logic               pos_re;
  logic [AW-1:0]      pos_raddr;
  logic signed [31:0] pos_rdata;
  logic signed [31:0] val_rdata;
  logic               val_re;

  logic signed [33:0] dnum, dden;
  logic signed [49:0] dnum_sh;
  logic [34:0]        rem_sh;
  logic               rem_ge;
  logic signed [31:0] qv;
  logic signed [31:0] ma, mb;
  logic signed [49:0] acc_new;
  logic               degen;
  logic signed [33:0] s_k, s_be, s_ga, s_one;
  logic signed [33:0] w0c_num;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    if (32'(element_count) > MAX_ELEMENTS) begin
      count_eff = EW'(MAX_ELEMENTS);
    end else begin
      count_eff = EW'(element_count);
    end
  end

  // Node memories, written by load words and read by the sequencer.
  assign load_we = start && !busy && (item.kind == KIND_LOAD) &&
                   (32'(item.node_index) < DEPTH);
  assign waddr   = AW'(item.node_index);

  always_comb begin
    pos_re    = 1'b1;
    pos_raddr = b0;
    case (state)
      ST_RD0:  pos_raddr = b0;
      ST_RD3:  pos_raddr = b0 + AW'(3);
      ST_CHK:  pos_raddr = b0 + AW'(1);
      ST_RD1:  pos_raddr = b0 + AW'(2);
      default: pos_re    = 1'b0;
    endcase
  end

  assign val_re = (state == ST_MAB);

  pcli_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_pos_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (waddr),
    .wdata (item.node_position),
    .re    (pos_re),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  pcli_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_val_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (waddr),
    .wdata (item.node_value),
    .re    (val_re),
    .raddr (b0 + AW'(wj)),
    .rdata (val_rdata)
  );

  // Divider operands: the three local coordinates, then the basis factors
  // whose denominators vary.
  assign s_k   = ext34(k);
  assign s_be  = ext34(be);
  assign s_ga  = ext34(ga);
  assign s_one = 34'sd65536;

  // The last factor of the first weight divides by minus one, a plain negation.
  assign w0c_num = s_one - s_k;

  always_comb begin
    case (op)
      4'd0: begin dnum = ext34(qx) - ext34(p0); dden = ext34(p3) - ext34(p0); end
      4'd1: begin dnum = ext34(p1) - ext34(p0); dden = ext34(p3) - ext34(p0); end
      4'd2: begin dnum = ext34(p2) - ext34(p0); dden = ext34(p3) - ext34(p0); end
      4'd3: begin dnum = s_k - s_be;  dden = -s_be; end
      4'd4: begin dnum = s_k - s_ga;  dden = -s_ga; end
      4'd6: begin dnum = s_k;         dden = s_be; end
      4'd7: begin dnum = s_k - s_ga;  dden = s_be - s_ga; end
      4'd8: begin dnum = s_k - s_one; dden = s_be - s_one; end
      4'd9: begin dnum = s_k;         dden = s_ga; end
      4'd10: begin dnum = s_k - s_be;  dden = s_ga - s_be; end
      4'd11: begin dnum = s_k - s_one; dden = s_ga - s_one; end
      4'd12: begin dnum = s_k - s_be;  dden = s_one - s_be; end
      default: begin dnum = s_k - s_ga; dden = s_one - s_ga; end
    endcase
  end

  assign dnum_sh = {dnum, 16'b0};
  assign rem_sh  = {rem[33:0], qr[49]};
  assign rem_ge  = (rem_sh >= {1'b0, dmag});

  // Truncated quotient magnitude in qr, saturated to the signed 32-bit range.
  always_comb begin
    if (!dneg) begin
      qv = (qr > 50'h7fffffff) ? 32'sh7fffffff : qr[31:0];
    end else begin
      qv = (qr > 50'h80000000) ? 32'sh80000000 : (~qr[31:0] + 32'd1);
    end
  end

  assign degen = (be == 32'sd0) || (qv == 32'sd0) || (be == qv) ||
                 (be == 32'sd65536) || (qv == 32'sd65536);

  always_comb begin
    case (state)
      ST_MAB:  begin ma = fac0; mb = fac1; end
      ST_MC:   begin ma = wt;   mb = fac2; end
      default: begin ma = wt;   mb = val_rdata; end
    endcase
  end

  assign acc_new = acc + {{2{prod[63]}}, prod[63:16]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      element_count <= 7'd1;
      done          <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        element_count <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (start && item.kind == KIND_EVAL) begin
            qx    <= item.query_x;
            ecnt  <= '0;
            b0    <= '0;
            found <= 1'b0;
            rval  <= '0;
            acc   <= '0;
            wj    <= '0;
            op    <= '0;
            state <= (count_eff == '0) ? ST_FIN : ST_RD0;
          end
        end
        ST_RD0: state <= ST_RD3;
        ST_RD3: begin
          p0    <= pos_rdata;
          state <= ST_CHK;
        end
        ST_CHK: begin
          if (qx >= p0 && qx <= pos_rdata) begin
            p3    <= pos_rdata;
            found <= 1'b1;
            state <= ST_RD1;
          end else if ((ecnt + EW'(1)) == count_eff) begin
            state <= ST_FIN;
          end else begin
            ecnt  <= ecnt + EW'(1);
            b0    <= b0 + AW'(3);
            state <= ST_RD0;
          end
        end
        ST_RD1: begin
          p1    <= pos_rdata;
          state <= ST_RD2;
        end
        ST_RD2: begin
          p2    <= pos_rdata;
          // A zero-width element ends the scan with a zero value.
          state <= (p3 == p0) ? ST_FIN : ST_DIVST;
        end
        ST_DIVST: begin
          dneg  <= dnum[33] ^ dden[33];
          qr    <= dnum_sh[49] ? (~dnum_sh + 50'd1) : dnum_sh;
          dmag  <= dden[33] ? (~dden + 34'd1) : dden;
          rem   <= '0;
          dcnt  <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          rem   <= rem_ge ? (rem_sh - {1'b0, dmag}) : rem_sh;
          qr    <= {qr[48:0], rem_ge};
          dcnt  <= dcnt + 6'd1;
          if (dcnt == DIV_LAST) begin
            state <= ST_DIVEND;
          end
        end
        ST_DIVEND: begin
          op <= (op == OP_W0B) ? (OP_W0C + 4'd1) : (op + 4'd1);
          case (op)
            4'd0: k  <= qv;
            4'd1: be <= qv;
            4'd2: ga <= qv;
            4'd3, 4'd6, 4'd9: fac0 <= qv;
            4'd4, 4'd7, 4'd10, 4'd12: fac1 <= qv;
            default: fac2 <= qv;
          endcase
          if (op == OP_GA) begin
            state <= degen ? ST_FIN : ST_DIVST;
          end else if (op == OP_W0B) begin
            fac2  <= sat48({{14{w0c_num[33]}}, w0c_num});
            state <= ST_MAB;
          end else if (op == OP_W1C || op == OP_W2C || op == OP_W3C) begin
            state <= ST_MAB;
          end else begin
            state <= ST_DIVST;
          end
        end
        ST_MAB: begin
          prod  <= ma * mb;
          state <= ST_MSAT1;
        end
        ST_MSAT1: begin
          wt    <= sat48(prod[63:16]);
          state <= ST_MC;
        end
        ST_MC: begin
          prod  <= ma * mb;
          state <= ST_MSAT2;
        end
        ST_MSAT2: begin
          wt    <= sat48(prod[63:16]);
          state <= ST_MF;
        end
        ST_MF: begin
          prod  <= ma * mb;
          state <= ST_MACC;
        end
        ST_MACC: begin
          acc <= acc_new;
          if (wj == 2'd3) begin
            rval  <= sat50(acc_new);
            state <= ST_FIN;
          end else begin
            // The last weight uses ksi itself as its first factor.
            if (wj == 2'd2) begin
              fac0 <= k;
            end
            wj    <= wj + 2'd1;
            state <= ST_DIVST;
          end
        end
        ST_FIN: begin
          done                <= 1'b1;
          result.spline_value <= rval;
          result.in_range     <= found;
          state               <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/pcli_checker.sv
// Port-level assertions for the interpolator, bound to its top level.
module pcli_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input pcli_pkg::item_t   item,
  input logic              done,
  input pcli_pkg::result_t result,
  input logic              cfg_valid,
  input logic              cfg_ready,
  input logic [6:0]        cfg_data
);
  import pcli_pkg::*;

  // An evaluate word always occupies the block: busy rises in the cycle after it is taken.
  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.kind == KIND_EVAL) |=> busy)
    else $error("evaluate word did not raise busy");

  // A load word produces no result and leaves the block free.
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.kind == KIND_LOAD) |=> (!busy && !done))
    else $error("load word raised busy or produced a result");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  a_out_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.in_range) |-> (result.spline_value == 32'sd0))
    else $error("value not zero for a point outside the grid");

  // Busy only ends by delivering the result word.
  a_fall_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without a result");

  logic unused_cfg;
  assign unused_cfg = cfg_valid ^ cfg_ready ^ (^cfg_data);

endmodule

bind piecewise_cubic_lagrange_interp pcli_checker u_pcli_checker (.*);
